// File: hw/rtl/srie_pkg.sv
// Shared types and constants of the status register instruction emulator.
`default_nettype none

package srie_pkg;

    // Opcode decode
    localparam logic [15:0] OP_MOVE_MASK    = 16'hFFC0;
    localparam logic [15:0] OP_MOVE_FROM_SR = 16'h40C0;
    localparam logic [15:0] OP_MOVE_TO_SR   = 16'h46C0;
    localparam logic [15:0] OP_ORI_SR       = 16'h007C;
    localparam logic [15:0] OP_ANDI_SR      = 16'h027C;
    localparam logic [15:0] EA_MASK         = 16'h003F;

    // Immediate checks
    localparam logic [15:0] IMM_ORI_MASK    = 16'hF000;
    localparam logic [15:0] IMM_ANDI_MASK   = 16'hFF00;
    localparam logic [15:0] SR_TOP_MASK     = 16'hF000;

    // Effective address codes
    localparam logic [5:0] EA_ABS_W   = 6'h38;
    localparam logic [5:0] EA_ABS_L   = 6'h39;
    localparam logic [5:0] EA_IMM_PC  = 6'h3C;
    localparam logic [2:0] MODE_POSTINC = 3'd3;
    localparam logic [2:0] MODE_PREDEC  = 3'd4;
    localparam logic [2:0] MODE_DISP    = 3'd5;
    localparam logic [2:0] MODE_INDEX   = 3'd6;

    typedef enum logic [2:0] {
        K_NONE,
        K_MV_FROM,
        K_MV_TO,
        K_ORI,
        K_ANDI
    } t_kind;

    // Source of the register write value
    typedef enum logic [1:0] {
        RS_LOW,
        RS_POST,
        RS_PRE
    } t_rsel;

    typedef struct packed {
        logic [15:0] opcode;
        logic [15:0] ext_word_first;
        logic [15:0] ext_word_second;
        logic [15:0] status_in;
        logic [31:0] pc_in;
        logic [31:0] base_reg;
        logic [31:0] index_reg;
        logic [15:0] operand_word;
    } t_req;

    typedef struct packed {
        logic        handled;
        logic [15:0] status_out;
        logic [31:0] pc_out;
        logic [31:0] operand_address;
        logic        mem_read;
        logic        mem_write;
        logic        reg_write;
        logic [3:0]  reg_number;
        logic [31:0] reg_value;
    } t_rsp;

    // Decode stage output
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic        handled;
        logic [31:0] addr_a;
        logic [31:0] addr_b;
        logic [31:0] pc;
        logic [2:0]  pc_inc;
        logic [31:0] base;
        logic [15:0] status;
        logic [15:0] ext1;
        logic [15:0] src;
        logic        mem_rd;
        logic        mem_wr;
        logic        reg_wr;
        logic [3:0]  rnum;
        t_rsel       rsel;
    } t_s1;

    // Address stage output
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic        handled;
        logic [31:0] addr;
        logic [31:0] pc_out;
        logic [15:0] status;
        logic [15:0] ext1;
        logic [15:0] src;
        logic        mem_rd;
        logic        mem_wr;
        logic        reg_wr;
        logic [3:0]  rnum;
        logic [31:0] rval;
    } t_s2;

endpackage

`default_nettype wire

// File: hw/rtl/status_register_instruction_emulator_core.sv
// Top level of the status register instruction emulator.
`default_nettype none

// Emulates trapped status-word instructions: MOVE from SR, MOVE to SR,
// ORI to SR and ANDI to SR. A request is taken on every clock edge where
// start is high and busy is low; busy is high only during reset and the
// cycle after it, so the block takes one request per cycle. Each request
// yields exactly one result, shown on o_rsp for a single cycle with
// o_valid high. The result passes through three register stages:
// decode, address/PC adders, result assembly. There is no backpressure
// on the result side, so results must be captured in the cycle they
// appear. Requests that are not emulated come back with handled low, the
// PC and status passed through and the side-effect fields zero.
module status_register_instruction_emulator_core (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    input  srie_pkg::t_req  i_req,
    output logic            o_valid,
    output srie_pkg::t_rsp  o_rsp
);
    import srie_pkg::*;

    logic r_busy;
    t_s1  s1;
    t_s2  s2;

    // Held off while in reset and for the first cycle after it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    // Stage 1: decode the opcode and pick the address adder operands.
    srie_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !r_busy),
        .i_req   (i_req),
        .o_s1    (s1)
    );

    // Stage 2: effective address, advanced PC, register update value.
    srie_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    // Stage 3: new status word, unhandled masking, output register.
    srie_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s2    (s2),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

// File: hw/rtl/srie_decode.sv
// Stage 1: opcode and effective address decode, address operand selection.
`default_nettype none

module srie_decode (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  srie_pkg::t_req  i_req,
    output srie_pkg::t_s1   o_s1
);
    import srie_pkg::*;

    t_s1         r_s1;
    t_s1         n_s1;
    logic [15:0] masked;
    logic [5:0]  ea;
    logic [2:0]  mode;
    logic        is_reg;
    logic        is_move;
    logic [1:0]  words;
    logic [31:0] ext_s16;
    logic [31:0] ext_s8;
    logic [31:0] ix;

    always_comb begin
        masked  = i_req.opcode & OP_MOVE_MASK;
        ea      = 6'(i_req.opcode & EA_MASK);
        mode    = ea[5:3];
        is_reg  = (ea[5:4] == 2'b00);
        is_move = (masked == OP_MOVE_FROM_SR) || (masked == OP_MOVE_TO_SR);
        ext_s16 = {{16{i_req.ext_word_first[15]}}, i_req.ext_word_first};
        ext_s8  = {{24{i_req.ext_word_first[7]}}, i_req.ext_word_first[7:0]};
        ix      = i_req.ext_word_first[11] ? i_req.index_reg
                : {{16{i_req.index_reg[15]}}, i_req.index_reg[15:0]};
        words   = 2'd0;

        n_s1         = '0;
        n_s1.valid   = i_valid;
        n_s1.kind    = K_NONE;
        n_s1.rsel    = RS_LOW;
        n_s1.pc      = i_req.pc_in;
        n_s1.base    = i_req.base_reg;
        n_s1.status  = i_req.status_in;
        n_s1.ext1    = i_req.ext_word_first;
        n_s1.src     = is_reg ? i_req.base_reg[15:0] : i_req.operand_word;

        if (is_move) begin
            n_s1.kind    = (masked == OP_MOVE_FROM_SR) ? K_MV_FROM : K_MV_TO;
            n_s1.handled = 1'b1;
            if (is_reg) begin
                if (masked == OP_MOVE_FROM_SR) begin
                    n_s1.reg_wr = 1'b1;
                    n_s1.rnum   = ea[3:0];
                    n_s1.rsel   = RS_LOW;
                end
            end else begin
                n_s1.mem_wr = (masked == OP_MOVE_FROM_SR);
                n_s1.mem_rd = (masked == OP_MOVE_TO_SR);
                case (ea)
                    EA_ABS_W: begin
                        n_s1.addr_b = ext_s16;
                        words       = 2'd1;
                    end
                    EA_ABS_L: begin
                        n_s1.addr_a = {i_req.ext_word_first, i_req.ext_word_second};
                        words       = 2'd2;
                    end
                    EA_IMM_PC: begin
                        n_s1.addr_a = i_req.pc_in;
                        n_s1.addr_b = 32'd2;
                        words       = 2'd1;
                    end
                    default: begin
                        n_s1.addr_a = i_req.base_reg;
                        case (mode)
                            MODE_PREDEC: begin
                                n_s1.addr_b = 32'hFFFF_FFFE;
                                n_s1.reg_wr = 1'b1;
                                n_s1.rnum   = {1'b1, ea[2:0]};
                                n_s1.rsel   = RS_PRE;
                            end
                            MODE_POSTINC: begin
                                n_s1.reg_wr = 1'b1;
                                n_s1.rnum   = {1'b1, ea[2:0]};
                                n_s1.rsel   = RS_POST;
                            end
                            MODE_DISP: begin
                                n_s1.addr_b = ext_s16;
                                words       = 2'd1;
                            end
                            MODE_INDEX: begin
                                n_s1.addr_b = ext_s8 + ix;
                                words       = 2'd1;
                            end
                            default: begin
                                n_s1.addr_b = 32'd0;
                            end
                        endcase
                    end
                endcase
            end
            n_s1.pc_inc = {words, 1'b0} + 3'd2;
        end else if (i_req.opcode == OP_ORI_SR) begin
            n_s1.kind    = K_ORI;
            n_s1.handled = ((i_req.ext_word_first & IMM_ORI_MASK) == 16'h0000);
            n_s1.pc_inc  = n_s1.handled ? 3'd4 : 3'd0;
        end else if (i_req.opcode == OP_ANDI_SR) begin
            n_s1.kind    = K_ANDI;
            n_s1.handled = ((i_req.ext_word_first & IMM_ANDI_MASK) == IMM_ANDI_MASK);
            n_s1.pc_inc  = n_s1.handled ? 3'd4 : 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

`default_nettype wire

// File: hw/rtl/srie_addr.sv
// Stage 2: address, PC and register write value adders.
`default_nettype none

module srie_addr (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  srie_pkg::t_s1  i_s1,
    output srie_pkg::t_s2  o_s2
);
    import srie_pkg::*;

    t_s2         r_s2;
    t_s2         n_s2;
    logic [31:0] addr;

    always_comb begin
        addr = i_s1.addr_a + i_s1.addr_b;

        n_s2         = '0;
        n_s2.valid   = i_s1.valid;
        n_s2.kind    = i_s1.kind;
        n_s2.handled = i_s1.handled;
        n_s2.addr    = addr;
        n_s2.pc_out  = i_s1.pc + {29'd0, i_s1.pc_inc};
        n_s2.status  = i_s1.status;
        n_s2.ext1    = i_s1.ext1;
        n_s2.src     = i_s1.src;
        n_s2.mem_rd  = i_s1.mem_rd;
        n_s2.mem_wr  = i_s1.mem_wr;
        n_s2.reg_wr  = i_s1.reg_wr;
        n_s2.rnum    = i_s1.rnum;
        if (i_s1.reg_wr) begin
            case (i_s1.rsel)
                RS_LOW:  n_s2.rval = {i_s1.base[31:16], i_s1.status};
                RS_POST: n_s2.rval = i_s1.base + 32'd2;
                RS_PRE:  n_s2.rval = addr;
                default: n_s2.rval = 32'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

`default_nettype wire

// File: hw/rtl/srie_result.sv
// Stage 3: new status word and assembly of the registered result.
`default_nettype none

module srie_result (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  srie_pkg::t_s2   i_s2,
    output logic            o_valid,
    output srie_pkg::t_rsp  o_rsp
);
    import srie_pkg::*;

    logic  r_valid;
    t_rsp  r_rsp;
    t_rsp  n_rsp;

    always_comb begin
        n_rsp            = '0;
        n_rsp.status_out = i_s2.status;
        n_rsp.pc_out     = i_s2.pc_out;
        if (i_s2.handled) begin
            n_rsp.handled         = 1'b1;
            n_rsp.operand_address = (i_s2.mem_rd || i_s2.mem_wr) ? i_s2.addr : 32'd0;
            n_rsp.mem_read        = i_s2.mem_rd;
            n_rsp.mem_write       = i_s2.mem_wr;
            n_rsp.reg_write       = i_s2.reg_wr;
            n_rsp.reg_number      = i_s2.rnum;
            n_rsp.reg_value       = i_s2.rval;
            case (i_s2.kind)
                K_MV_TO: begin
                    // only accepted when the top nibble is left alone
                    if (((i_s2.status ^ i_s2.src) & SR_TOP_MASK) == 16'h0000) begin
                        n_rsp.status_out = i_s2.src;
                    end
                end
                K_ORI:   n_rsp.status_out = i_s2.status | i_s2.ext1;
                K_ANDI:  n_rsp.status_out = i_s2.status & i_s2.ext1;
                default: n_rsp.status_out = i_s2.status;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_s2.valid;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

`default_nettype wire

// File: hw/rtl/srie_checker.sv
// Port-level checker for the status register instruction emulator, with bind.
`default_nettype none

module srie_checker (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    input  wire             busy,
    input  srie_pkg::t_req  i_req,
    input  wire             o_valid,
    input  srie_pkg::t_rsp  o_rsp
);
    import srie_pkg::*;

    // Every accepted request produces a result once it has passed the decode, address and result registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("request accepted without a result three cycles later");

    // No result without a matching accepted request ahead of it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("result without a matching request");

    // Unhandled results restore the PC and carry no side effects.
    a_unhandled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_rsp.handled) |->
            (o_rsp.pc_out == $past(i_req.pc_in, 3)) && !o_rsp.mem_read &&
            !o_rsp.mem_write && !o_rsp.reg_write &&
            (o_rsp.status_out == $past(i_req.status_in, 3)))
        else $error("unhandled result with side effects");

    // A result never reads and writes memory at once.
    a_mem_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rsp.mem_read && o_rsp.mem_write))
        else $error("memory read and write in the same result");

endmodule

bind status_register_instruction_emulator_core srie_checker u_srie_checker (.*);

`default_nettype wire

// File: tb/sv/status_register_instruction_emulator_core_test.sv
// Self-checking testbench for the status register instruction emulator core.
`timescale 1ns / 1ps

module status_register_instruction_emulator_core_test;

    import srie_pkg::*;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_valid;
    t_rsp  o_rsp;

    // Trapped instructions not yet offered to the block.
    t_req  trap_queue[$];
    // Predicted emulation results, oldest first.
    t_rsp  awaited_rsp[$];
    // Chance (percent) that the driver leaves a cycle empty.
    int    idle_pct   = 31;
    int    mismatches = 0;

    status_register_instruction_emulator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or drops results.
    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: what the emulator should do with one trapped instruction.
    // Register modes (ea 0-15) use the low word of the register; memory
    // modes resolve an address and use the memory word. Anything that is
    // not emulated passes PC and status through with all else zero.
    // ------------------------------------------------------------------
    function automatic t_rsp emulate_sr_insn(t_req r);
        t_rsp        res;
        logic [5:0]  ea;
        logic [2:0]  mode;
        logic [2:0]  areg;
        logic [31:0] addr;
        logic [31:0] ix;
        logic [31:0] words;
        logic [15:0] src;
        logic        mv_from;
        logic        mv_to;
        res            = '0;
        res.status_out = r.status_in;
        res.pc_out     = r.pc_in;
        mv_from = (r.opcode & OP_MOVE_MASK) == OP_MOVE_FROM_SR;
        mv_to   = (r.opcode & OP_MOVE_MASK) == OP_MOVE_TO_SR;
        if (mv_from || mv_to) begin
            ea    = r.opcode[5:0];
            mode  = ea[5:3];
            areg  = ea[2:0];
            words = 32'd0;
            addr  = 32'd0;
            res.handled = 1'b1;
            if (ea < 6'd16) begin
                src = r.base_reg[15:0];
                // Destination register keeps its upper word.
                if (mv_from) begin
                    res.reg_write  = 1'b1;
                    res.reg_number = ea[3:0];
                    res.reg_value  = {r.base_reg[31:16], r.status_in};
                end
            end else begin
                if (ea == EA_ABS_W) begin
                    addr  = {{16{r.ext_word_first[15]}}, r.ext_word_first};
                    words = 32'd1;
                end else if (ea == EA_ABS_L) begin
                    addr  = {r.ext_word_first, r.ext_word_second};
                    words = 32'd2;
                end else if (ea == EA_IMM_PC) begin
                    // Immediate form is read from memory at pc+2.
                    addr  = r.pc_in + 32'd2;
                    words = 32'd1;
                end else if (mode == MODE_PREDEC) begin
                    addr           = r.base_reg - 32'd2;
                    res.reg_write  = 1'b1;
                    res.reg_number = {1'b1, areg};
                    res.reg_value  = addr;
                end else if (mode == MODE_POSTINC) begin
                    addr           = r.base_reg;
                    res.reg_write  = 1'b1;
                    res.reg_number = {1'b1, areg};
                    res.reg_value  = r.base_reg + 32'd2;
                end else if (mode == MODE_DISP) begin
                    addr  = r.base_reg + {{16{r.ext_word_first[15]}}, r.ext_word_first};
                    words = 32'd1;
                end else if (mode == MODE_INDEX) begin
                    // Bit 11 selects long index, else sign-extended word.
                    ix = r.ext_word_first[11] ? r.index_reg
                                              : {{16{r.index_reg[15]}}, r.index_reg[15:0]};
                    addr  = r.base_reg + {{24{r.ext_word_first[7]}}, r.ext_word_first[7:0]}
                            + ix;
                    words = 32'd1;
                end else begin
                    // Mode 2 and leftover mode 7 codes: plain (An), no extension.
                    addr = r.base_reg;
                end
                src                 = r.operand_word;
                res.operand_address = addr;
                res.mem_write       = mv_from;
                res.mem_read        = mv_to;
            end
            // MOVE to SR only lands if the top nibble is unchanged.
            if (mv_to && ((r.status_in ^ src) & SR_TOP_MASK) == 16'd0) begin
                res.status_out = src;
            end
            res.pc_out = r.pc_in + 32'd2 + 32'd2 * words;
        end else if (r.opcode == OP_ORI_SR && (r.ext_word_first & IMM_ORI_MASK) == 16'd0) begin
            res.handled    = 1'b1;
            res.status_out = r.status_in | r.ext_word_first;
            res.pc_out     = r.pc_in + 32'd4;
        end else if (r.opcode == OP_ANDI_SR &&
                     (r.ext_word_first & IMM_ANDI_MASK) == IMM_ANDI_MASK) begin
            res.handled    = 1'b1;
            res.status_out = r.status_in & r.ext_word_first;
            res.pc_out     = r.pc_in + 32'd4;
        end
        return res;
    endfunction

    // Fully random request; callers override the opcode and friends.
    function automatic t_req random_trap(logic [15:0] op);
        t_req r;
        r.opcode          = op;
        r.ext_word_first  = 16'($urandom);
        r.ext_word_second = 16'($urandom);
        r.status_in       = 16'($urandom);
        r.pc_in           = $urandom;
        r.base_reg        = $urandom;
        r.index_reg       = $urandom;
        r.operand_word    = 16'($urandom);
        return r;
    endfunction

    // Random request biased toward instructions that actually get emulated.
    function automatic t_req random_emulated();
        t_req        r;
        int          pick;
        logic [5:0]  ea;
        pick = $urandom_range(99);
        ea   = 6'($urandom_range(63));
        if (pick < 35) begin
            r = random_trap(OP_MOVE_FROM_SR | {10'd0, ea});
        end else if (pick < 70) begin
            r = random_trap(OP_MOVE_TO_SR | {10'd0, ea});
            // Half the time make the new status legal.
            if ($urandom_range(1)) begin
                r.base_reg[15:12]     = r.status_in[15:12];
                r.operand_word[15:12] = r.status_in[15:12];
            end
        end else if (pick < 80) begin
            r = random_trap(OP_ORI_SR);
            if ($urandom_range(3) != 0) r.ext_word_first[15:12] = 4'h0;
        end else if (pick < 90) begin
            r = random_trap(OP_ANDI_SR);
            if ($urandom_range(3) != 0) r.ext_word_first[15:8] = 8'hFF;
        end else begin
            // Noise: arbitrary opcode, mostly not emulated.
            r = random_trap(16'($urandom));
        end
        // Push the address adders into their wrap-around corners now and then.
        case ($urandom_range(9))
            0: r.base_reg = 32'h0000_0000;
            1: r.base_reg = 32'hFFFF_FFFF;
            2: r.pc_in    = 32'hFFFF_FFFE;
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: a request goes in when start is high and busy is low at the
    // edge. The prediction is made from the request the block just took,
    // then the next request is put up (or a gap left) with one update.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        if (i_rst_n) begin
            if (start && !busy) begin
                awaited_rsp.push_back(emulate_sr_insn(i_req));
            end
            // Hold the request while busy, otherwise move on.
            if (!start || !busy) begin
                if (trap_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    i_req <= trap_queue.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: results show for one cycle only; each strobe is matched
    // against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_rsp exp_rsp;
        if (i_rst_n && o_valid) begin
            if (awaited_rsp.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_rsp);
                mismatches++;
            end else begin
                exp_rsp = awaited_rsp.pop_front();
                check_field("handled", 32'(exp_rsp.handled), 32'(o_rsp.handled));
                check_field("status_out", 32'(exp_rsp.status_out), 32'(o_rsp.status_out));
                check_field("pc_out",          exp_rsp.pc_out,          o_rsp.pc_out);
                check_field("operand_address", exp_rsp.operand_address, o_rsp.operand_address);
                check_field("mem_read", 32'(exp_rsp.mem_read), 32'(o_rsp.mem_read));
                check_field("mem_write", 32'(exp_rsp.mem_write), 32'(o_rsp.mem_write));
                check_field("reg_write", 32'(exp_rsp.reg_write), 32'(o_rsp.reg_write));
                check_field("reg_number", 32'(exp_rsp.reg_number), 32'(o_rsp.reg_number));
                check_field("reg_value",       exp_rsp.reg_value,       o_rsp.reg_value);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, a directed set, then three random phases with the
    // sender gapping 31%, 67% and never.
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_req r;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes on non-emulated opcodes.
        r = '0;
        trap_queue.push_back(r);
        r = '1;
        trap_queue.push_back(r);

        // MOVE from SR: data reg, address reg, every memory mode.
        trap_queue.push_back(random_trap(OP_MOVE_FROM_SR | 16'h0003));
        trap_queue.push_back(random_trap(OP_MOVE_FROM_SR | 16'h000D));
        trap_queue.push_back(random_trap(OP_MOVE_FROM_SR | 16'h0012));
        r = random_trap(OP_MOVE_FROM_SR | 16'h001F);   // (A7)+ wrapping up
        r.base_reg = 32'hFFFF_FFFF;
        trap_queue.push_back(r);
        r = random_trap(OP_MOVE_FROM_SR | 16'h0020);   // -(A0) wrapping down
        r.base_reg = 32'h0000_0000;
        trap_queue.push_back(r);
        r = random_trap(OP_MOVE_FROM_SR | 16'h0029);   // most negative d16
        r.ext_word_first = 16'h8000;
        trap_queue.push_back(r);
        r = random_trap(OP_MOVE_FROM_SR | 16'h0036);   // long index, negative d8
        r.ext_word_first = 16'h0880;
        trap_queue.push_back(r);
        r = random_trap(OP_MOVE_FROM_SR | 16'h0036);   // word index
        r.ext_word_first = 16'h007F;
        r.index_reg      = 32'h1234_8000;
        trap_queue.push_back(r);
        r = random_trap(OP_MOVE_FROM_SR | {10'd0, EA_ABS_W});
        r.ext_word_first = 16'hFFFE;
        trap_queue.push_back(r);
        trap_queue.push_back(random_trap(OP_MOVE_FROM_SR | {10'd0, EA_ABS_L}));
        r = random_trap(OP_MOVE_FROM_SR | {10'd0, EA_IMM_PC});
        r.pc_in = 32'hFFFF_FFFE;
        trap_queue.push_back(r);
        trap_queue.push_back(random_trap(OP_MOVE_FROM_SR | 16'h003A));
        trap_queue.push_back(random_trap(OP_MOVE_FROM_SR | 16'h003F));

        // MOVE to SR: register source with matching and differing nibble.
        r = random_trap(OP_MOVE_TO_SR | 16'h0000);
        r.status_in = 16'hF123;
        r.base_reg  = 32'hABCD_F456;
        trap_queue.push_back(r);
        r.base_reg  = 32'hABCD_7456;
        trap_queue.push_back(r);
        // Rejected status still bumps the address register.
        r = random_trap(OP_MOVE_TO_SR | 16'h001B);
        r.status_in    = 16'h2700;
        r.operand_word = 16'h0000;
        trap_queue.push_back(r);
        // Immediate form through memory, accepted.
        r = random_trap(OP_MOVE_TO_SR | {10'd0, EA_IMM_PC});
        r.operand_word[15:12] = r.status_in[15:12];
        trap_queue.push_back(r);

        // ORI / ANDI at the edge of their immediate checks.
        r = random_trap(OP_ORI_SR);
        r.ext_word_first = 16'h0FFF;
        trap_queue.push_back(r);
        r.ext_word_first = 16'h1000;
        trap_queue.push_back(r);
        r = random_trap(OP_ANDI_SR);
        r.ext_word_first = 16'hFF00;
        trap_queue.push_back(r);
        r.ext_word_first = 16'hFEFF;
        trap_queue.push_back(r);
        // Near miss on the ANDI opcode.
        r.opcode = OP_ANDI_SR | 16'h0001;
        r.ext_word_first = 16'hFFFF;
        trap_queue.push_back(r);

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 31 : (phase == 1) ? 67 : 0;
            repeat (150) trap_queue.push_back(random_emulated());
            // Let this phase drain into the block before changing the gap rate.
            while (trap_queue.size() != 0 || start) @(posedge i_clk);
        end

        while (awaited_rsp.size() != 0) @(posedge i_clk);
        // Three-stage pipe: wait on after the last result to catch any stray strobe.
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/srie_pkg.sv
hw/rtl/srie_decode.sv
hw/rtl/srie_addr.sv
hw/rtl/srie_result.sv
hw/rtl/status_register_instruction_emulator_core.sv
hw/rtl/srie_checker.sv
tb/sv/status_register_instruction_emulator_core_test.sv
